/* rtl/audio_channel_router_macros.svh */
// Assertion macros for the audio channel router checker.
`ifndef AUDIO_CHANNEL_ROUTER_MACROS_SVH
`define AUDIO_CHANNEL_ROUTER_MACROS_SVH

// Same-cycle implication.
`define ACR_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ACR_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/acr_pkg.sv */
// Package: constants, types and routing functions of the audio channel router.
`default_nettype none
package acr_pkg;
	localparam int MAX_CHANNELS = 8;
	localparam int SAMPLE_WIDTH = 32;
	localparam int CH_W = $clog2(MAX_CHANNELS);
	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
	localparam int REG_W = 4;
	localparam int PAIRS = 8;
	localparam int FIELD_W = 3;
	localparam int ROUTE_W = PAIRS * FIELD_W;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int RAM_DEPTH = 2 * MAX_CHANNELS;
	localparam int RAM_AW = $clog2(RAM_DEPTH);
	localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

	typedef enum logic [2:0] {
		REG_IN_CH    = 3'd0,
		REG_OUT_CH   = 3'd1,
		REG_PAIR_CNT = 3'd2,
		REG_FROM     = 3'd3,
		REG_TO       = 3'd4
	} reg_idx_t;

	localparam logic [REG_W-1:0] IN_CH_RST = 4'd2;
	localparam logic [REG_W-1:0] OUT_CH_RST = 4'd2;
	localparam logic [REG_W-1:0] PAIR_CNT_RST = 4'd2;
	localparam logic [ROUTE_W-1:0] ROUTE_RST = 24'hFAC688;

	typedef struct packed {
		logic [REG_W-1:0]   in_ch;
		logic [REG_W-1:0]   out_ch;
		logic [REG_W-1:0]   pair_cnt;
		logic [ROUTE_W-1:0] from;
		logic [ROUTE_W-1:0] to;
	} cfg_t;

	typedef struct packed {
		logic pend;
		logic bank;
	} frm_t;

	typedef struct packed {
		logic            hit;
		logic [CH_W-1:0] src;
	} src_t;

	function automatic logic [CNT_W-1:0] clamp_ch(input logic [REG_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0)
			r = CNT_W'(1);
		else if (32'(v) > MAX_CHANNELS)
			r = CNT_W'(MAX_CHANNELS);
		else
			r = CNT_W'(v);
		return r;
	endfunction

	function automatic logic route_ok(input cfg_t c);
		logic             ok;
		logic [CNT_W-1:0] nin;
		logic [CNT_W-1:0] nout;
		logic [FIELD_W-1:0] f;
		logic [FIELD_W-1:0] t;
		nin = clamp_ch(c.in_ch);
		nout = clamp_ch(c.out_ch);
		ok = (c.pair_cnt != '0) && (32'(c.pair_cnt) <= MAX_CHANNELS);
		for (int i = 0; i < PAIRS; i++) begin
			f = c.from[i*FIELD_W +: FIELD_W];
			t = c.to[i*FIELD_W +: FIELD_W];
			if (32'(i) < 32'(c.pair_cnt)) begin
				if (32'(f) >= 32'(nin) || 32'(t) >= 32'(nout))
					ok = 1'b0;
			end
		end
		return ok;
	endfunction

	// last active pair that targets ch wins
	function automatic src_t route_src(input cfg_t c, input logic [CH_W-1:0] ch);
		src_t r;
		r = '0;
		for (int i = 0; i < PAIRS; i++) begin
			if (32'(i) < 32'(c.pair_cnt) &&
			    32'(c.to[i*FIELD_W +: FIELD_W]) == 32'(ch)) begin
				r.hit = 1'b1;
				r.src = CH_W'(c.from[i*FIELD_W +: FIELD_W]);
			end
		end
		return r;
	endfunction
endpackage
`default_nettype wire

/* rtl/acr_ram.sv */
// Generic single-write, single-read RAM with registered read (read-first).
`default_nettype none
module acr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* rtl/acr_cfg.sv */
// APB register file holding channel counts and routing pairs.
`default_nettype none
module acr_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [acr_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [acr_pkg::DATA_W-1:0]  pwdata,
	output logic      [acr_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	output acr_pkg::cfg_t                    cfg
);
	import acr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_ch <= IN_CH_RST;
			cfg_q.out_ch <= OUT_CH_RST;
			cfg_q.pair_cnt <= PAIR_CNT_RST;
			cfg_q.from <= ROUTE_RST;
			cfg_q.to <= ROUTE_RST;
		end else if (wr) begin
			unique case (idx)
				REG_IN_CH:    cfg_q.in_ch <= pwdata[REG_W-1:0];
				REG_OUT_CH:   cfg_q.out_ch <= pwdata[REG_W-1:0];
				REG_PAIR_CNT: cfg_q.pair_cnt <= pwdata[REG_W-1:0];
				REG_FROM:     cfg_q.from <= pwdata[ROUTE_W-1:0];
				REG_TO:       cfg_q.to <= pwdata[ROUTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_IN_CH:    prdata = DATA_W'(cfg_q.in_ch);
			REG_OUT_CH:   prdata = DATA_W'(cfg_q.out_ch);
			REG_PAIR_CNT: prdata = DATA_W'(cfg_q.pair_cnt);
			REG_FROM:     prdata = DATA_W'(cfg_q.from);
			REG_TO:       prdata = DATA_W'(cfg_q.to);
			default:      prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/acr_drain.sv */
// Output side: walks output channels of a finished frame, reads the routed
// sample from the frame RAM and presents it through an output register.
`default_nettype none
module acr_drain (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire acr_pkg::cfg_t                    cfg,
	input  wire acr_pkg::frm_t                    frm,
	output logic                                  take,
	output logic                                  rd_en,
	output logic      [acr_pkg::RAM_AW-1:0]       rd_addr,
	input  wire logic [acr_pkg::SAMPLE_WIDTH-1:0] rd_data,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [acr_pkg::TDATA_W-1:0]      m_tdata,  // [31:0] out_sample
	output logic      [acr_pkg::CH_W:0]           m_tuser,  // [2:0] out_channel, [3] route_error
	output logic                                  m_tlast
);
	import acr_pkg::*;

	logic             act_q;
	logic             bank_q;
	logic [CH_W-1:0]  ch_q;
	logic [CNT_W-1:0] nout;
	logic             last_ch;
	logic             fin;
	logic             ok;
	src_t             sel;

	logic             v_s1;
	logic [CH_W-1:0]  ch_s1;
	logic             last_s1;
	logic             err_s1;
	logic             sil_s1;

	logic                    out_v_q;
	logic [SAMPLE_WIDTH-1:0] out_d_q;
	logic [CH_W-1:0]         out_ch_q;
	logic                    out_last_q;
	logic                    out_err_q;

	logic mv;
	logic s1_free;

	assign nout = clamp_ch(cfg.out_ch);
	assign ok = route_ok(cfg);
	assign sel = route_src(cfg, ch_q);
	assign last_ch = (CNT_W'(ch_q) + CNT_W'(1)) == nout;

	assign mv = v_s1 && (!out_v_q || m_tready);
	assign s1_free = !v_s1 || mv;
	assign rd_en = act_q && s1_free;
	assign rd_addr = {bank_q, sel.src};
	assign fin = rd_en && last_ch;
	assign take = frm.pend && (!act_q || fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			bank_q <= 1'b0;
			ch_q <= '0;
		end else if (take) begin
			act_q <= 1'b1;
			bank_q <= frm.bank;
			ch_q <= '0;
		end else if (fin) begin
			act_q <= 1'b0;
		end else if (rd_en) begin
			ch_q <= ch_q + CH_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (rd_en)
			v_s1 <= 1'b1;
		else if (mv)
			v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ch_s1 <= ch_q;
			last_s1 <= last_ch;
			err_s1 <= !ok;
			sil_s1 <= !ok || !sel.hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (mv)
			out_v_q <= 1'b1;
		else if (m_tready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (mv) begin
			out_d_q <= sil_s1 ? '0 : rd_data;
			out_ch_q <= ch_s1;
			out_last_q <= last_s1;
			out_err_q <= err_s1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = TDATA_W'(out_d_q);
	assign m_tuser = {out_err_q, out_ch_q};
	assign m_tlast = out_last_q;
endmodule
`default_nettype wire

/* rtl/audio_channel_router.sv */
// Top level of the audio channel router: frame collection and block wiring.
//
// Interleaved samples enter on the s_ stream, one per cycle, and are written
// into a two-bank 16 x 32 frame RAM. When a frame of in_channels samples is
// complete, its bank is handed to the output side, which emits out_channels
// routed samples on the m_ stream, one per cycle unless m_tready stalls it,
// while the next frame fills the other bank. A routed sample passes from the
// RAM read register through the output register. Input stalls only when a
// second frame is finished while the previous one is still draining, i.e.
// sustained rate is one sample per cycle as long as out_channels <=
// in_channels and m_tready is high, else it is bound by the single RAM read
// port. s_tlast ends a buffer: a partial frame is dropped. Registers are
// written through APB and should only change while the block is idle.
`default_nettype none
module audio_channel_router (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [acr_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [acr_pkg::DATA_W-1:0]       pwdata,
	output logic      [acr_pkg::DATA_W-1:0]       prdata,
	output logic                                  pready,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [acr_pkg::TDATA_W-1:0]      s_tdata,  // [31:0] sample
	input  wire logic                             s_tlast,  // block_end
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [acr_pkg::TDATA_W-1:0]      m_tdata,  // [31:0] out_sample
	output logic      [acr_pkg::CH_W:0]           m_tuser,  // [2:0] out_channel, [3] route_error
	output logic                                  m_tlast
);
	import acr_pkg::*;

	cfg_t cfg;
	frm_t frm;
	logic take;

	logic             wbank_q;
	logic [CH_W-1:0]  pos_q;
	logic             pend_q;
	logic             pbank_q;
	logic             acc;
	logic             done;
	logic [CNT_W-1:0] nin;

	logic                    rd_en;
	logic [RAM_AW-1:0]       rd_addr;
	logic [SAMPLE_WIDTH-1:0] rd_data;

	acr_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	assign nin = clamp_ch(cfg.in_ch);
	// while a finished frame waits, the write bank is the one being drained
	assign s_tready = !pend_q || take;
	assign acc = s_tvalid && s_tready;
	assign done = (CNT_W'(pos_q) + CNT_W'(1)) >= nin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wbank_q <= 1'b0;
			pos_q <= '0;
			pend_q <= 1'b0;
			pbank_q <= 1'b0;
		end else begin
			if (acc) begin
				if (done) begin
					pos_q <= '0;
					wbank_q <= !wbank_q;
				end else if (s_tlast) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + CH_W'(1);
				end
			end
			if (acc && done) begin
				pend_q <= 1'b1;
				pbank_q <= wbank_q;
			end else if (take) begin
				pend_q <= 1'b0;
			end
		end
	end

	assign frm.pend = pend_q;
	assign frm.bank = pbank_q;

	acr_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk(clk),
		.we(acc),
		.waddr({wbank_q, pos_q}),
		.wdata(s_tdata[SAMPLE_WIDTH-1:0]),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	acr_drain u_drain (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.frm(frm),
		.take(take),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);
endmodule
`default_nettype wire

/* rtl/acr_checker.sv */
// Port-level checker for the audio channel router, bound to the top level.
`default_nettype none
`include "audio_channel_router_macros.svh"
module acr_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        m_tvalid,
	input wire logic                        m_tready,
	input wire logic [acr_pkg::TDATA_W-1:0] m_tdata,
	input wire logic [acr_pkg::CH_W:0]      m_tuser,
	input wire logic                        m_tlast
);
	import acr_pkg::*;

	`ACR_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

	`ACR_ASSERT_IMP(a_err_silent, clk, arst_n, m_tvalid && m_tuser[CH_W], m_tdata == '0, "route error with nonzero sample")

	`ACR_ASSERT_IMP(a_top_ch_last, clk, arst_n, m_tvalid && (m_tuser[CH_W-1:0] == CH_W'(MAX_CHANNELS - 1)), m_tlast, "highest channel not marked last")
endmodule

bind audio_channel_router acr_checker u_chk (.*);
`default_nettype wire

/* test/audio_channel_router_tb.sv */
// Self-checking testbench for audio_channel_router: directed table, then random frames.
`timescale 1ns / 100ps
module audio_channel_router_tb;
	import acr_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int N_ROWS = 45;
	localparam int ITEMS_PER_SET = 60;
	localparam logic [2:0] REG_SPARE = 3'd5;

	typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [31:0] data;   // register value, or sample
		logic        last;
		logic        typed;  // expected frame given in the row
		logic        err;
		logic [31:0] out0;
		logic [31:0] out1;
	} stim_row_t;

	typedef struct packed {
		logic [31:0] smp;
		logic [2:0]  ch;
		logic        last;
		logic        err;
	} routed_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                s_tvalid;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata;   // [31:0] sample
	logic                s_tlast;   // block_end
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;   // [31:0] out_sample
	logic [CH_W:0]       m_tuser;   // [2:0] out_channel, [3] route_error
	logic                m_tlast;

	// predictor state
	logic [3:0]  cfg_in;
	logic [3:0]  cfg_out;
	logic [3:0]  cfg_pairs;
	logic [23:0] cfg_src;
	logic [23:0] cfg_dst;
	logic [31:0] frame_copy [8];
	logic [2:0]  fill_pos;
	routed_t     frame_out [8];

	routed_t pending_results [$];
	int      mismatch_count = 0;
	int      cycle_count = 0;
	int      snd_idle_pct = 0;
	int      rcv_idle_pct = 0;
	int      hold_asks = 0;
	int      hold_taken = 0;
	int      hold_left = 0;

	stim_row_t directed_rows [N_ROWS] = '{
		'{ROW_ITEM,  REG_IN_CH,    32'hFFFFFFFF, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h00000000, 1'b0, 1'b1, 1'b0, 32'hFFFFFFFF, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h12345678, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h80000001, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h7FFFFFFE, 1'b1, 1'b1, 1'b0, 32'h80000001, 32'h7FFFFFFE},
		'{ROW_WRITE, REG_PAIR_CNT, 32'h00000000, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'hA5A5A5A5, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h5A5A5A5A, 1'b0, 1'b1, 1'b1, 32'h0, 32'h0},
		'{ROW_WRITE, REG_PAIR_CNT, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h0000FFFF, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'hFFFF0000, 1'b0, 1'b1, 1'b1, 32'h0, 32'h0},
		'{ROW_WRITE, REG_PAIR_CNT, 32'h00000002, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_WRITE, REG_FROM,     32'h00FAC698, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h00000001, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h00000002, 1'b0, 1'b1, 1'b1, 32'h0, 32'h0},
		'{ROW_WRITE, REG_FROM,     32'h00FAC688, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_WRITE, REG_TO,       32'hFFFAC698, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h00000003, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h00000004, 1'b0, 1'b1, 1'b1, 32'h0, 32'h0},
		'{ROW_WRITE, REG_SPARE,    32'h00000000, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_WRITE, REG_TO,       32'h00FAC688, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_WRITE, REG_IN_CH,    32'h00000000, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_WRITE, REG_OUT_CH,   32'h0000000F, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_WRITE, REG_PAIR_CNT, 32'h00000008, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_WRITE, REG_FROM,     32'h00000000, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'hFFFFFFFF, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_WRITE, REG_IN_CH,    32'h00000008, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_WRITE, REG_OUT_CH,   32'h00000001, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_WRITE, REG_FROM,     32'h00FAC688, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_WRITE, REG_TO,       32'h00000000, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h01010101, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h02020202, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h04040404, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h08080808, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h10101010, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h20202020, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h40404040, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h80808080, 1'b1, 1'b1, 1'b0, 32'h80808080, 32'h0},
		'{ROW_WRITE, REG_IN_CH,    32'h00000003, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_WRITE, REG_OUT_CH,   32'h00000002, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_WRITE, REG_PAIR_CNT, 32'h00000001, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'hCAFEF00D, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h0BADBEEF, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_WRITE, REG_IN_CH,    32'h00000001, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM,  REG_IN_CH,    32'h13579BDF, 1'b0, 1'b1, 1'b0, 32'hCAFEF00D, 32'h0}
	};

	audio_channel_router DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [3:0] eff_count(input logic [3:0] v);
		if (v == 4'd0)
			return 4'd1;
		if (v > 4'd8)
			return 4'd8;
		return v;
	endfunction

	// one sample into the frame; returns the number of routed samples it releases
	function automatic int route_sample(input logic [31:0] smp, input logic blk_end);
		logic [3:0]  nin;
		logic [3:0]  nout;
		logic [2:0]  pos;
		logic        ok;
		logic [31:0] v;
		nin = eff_count(cfg_in);
		nout = eff_count(cfg_out);
		pos = fill_pos;
		frame_copy[pos] = smp;
		if ({1'b0, pos} + 4'd1 < nin) begin
			fill_pos = blk_end ? 3'd0 : pos + 3'd1;
			return 0;
		end
		fill_pos = 3'd0;
		ok = (cfg_pairs >= 4'd1) && (cfg_pairs <= 4'd8);
		for (int i = 0; i < 8; i++) begin
			if (i < int'(cfg_pairs)) begin
				if ({1'b0, cfg_src[3*i +: 3]} >= nin || {1'b0, cfg_dst[3*i +: 3]} >= nout)
					ok = 1'b0;
			end
		end
		for (int c = 0; c < int'(nout); c++) begin
			v = 32'd0;
			if (ok) begin
				for (int i = 0; i < int'(cfg_pairs) && i < 8; i++) begin
					if (cfg_dst[3*i +: 3] == 3'(c))
						v = frame_copy[cfg_src[3*i +: 3]];
				end
			end
			frame_out[c].smp = v;
			frame_out[c].ch = 3'(c);
			frame_out[c].last = (c + 1 == int'(nout));
			frame_out[c].err = !ok;
		end
		return int'(nout);
	endfunction

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_IN_CH:    cfg_in = data[3:0];
			REG_OUT_CH:   cfg_out = data[3:0];
			REG_PAIR_CNT: cfg_pairs = data[3:0];
			REG_FROM:     cfg_src = data[23:0];
			REG_TO:       cfg_dst = data[23:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic offer_sample(input logic [31:0] smp, input logic blk_end, input logic typed,
			input logic t_err, input logic [31:0] t0, input logic [31:0] t1);
		routed_t r;
		int      n;
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tlast <= blk_end;
		do @(posedge clk); while (s_tready !== 1'b1);
		n = route_sample(smp, blk_end);
		for (int c = 0; c < n; c++) begin
			r = frame_out[c];
			if (typed) begin
				r.err = t_err;
				r.smp = t_err ? 32'd0 : (c == 0) ? t0 : (c == 1) ? t1 : 32'd0;
			end
			pending_results.push_back(r);
		end
	endtask

	// stop offering, wait for outstanding results, optionally let the pipeline settle
	task automatic settle(input bit full);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		if (full)
			repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_config(input bit pressure);
		logic [3:0]  nin;
		logic [3:0]  nout;
		logic [3:0]  pairs;
		logic [3:0]  ein;
		logic [3:0]  eout;
		logic [23:0] src_map;
		logic [23:0] dst_map;
		logic [31:0] rnd;
		if (pressure) begin
			nin = 4'd1;
			nout = 4'd8;
			pairs = 4'd8;
			src_map = 24'd0;
			dst_map = 24'hFAC688;
		end else begin
			nin = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
			nout = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
			pairs = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
			ein = eff_count(nin);
			eout = eff_count(nout);
			for (int i = 0; i < 8; i++) begin
				src_map[3*i +: 3] = 3'($urandom_range(0, int'(ein) - 1));
				dst_map[3*i +: 3] = 3'($urandom_range(0, int'(eout) - 1));
			end
			if ($urandom_range(0, 7) == 0) begin
				src_map = 24'($urandom);
				dst_map = 24'($urandom);
			end
		end
		rnd = $urandom;
		cfg_write(REG_IN_CH, {rnd[31:4], nin});
		rnd = $urandom;
		cfg_write(REG_OUT_CH, {rnd[31:4], nout});
		rnd = $urandom;
		cfg_write(REG_PAIR_CNT, {rnd[31:4], pairs});
		rnd = $urandom;
		cfg_write(REG_FROM, {rnd[31:24], src_map});
		rnd = $urandom;
		cfg_write(REG_TO, {rnd[31:24], dst_map});
	endtask

	always @(negedge clk) begin
		if (hold_taken != hold_asks) begin
			hold_taken++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		routed_t want;
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: out_sample %h out_channel %0d", m_tdata,
					m_tuser[CH_W-1:0]);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== want.smp) begin
					$error("out_sample: expected %h, got %h", want.smp, m_tdata);
					mismatch_count++;
				end
				if (m_tuser[CH_W-1:0] !== want.ch) begin
					$error("out_channel: expected %0d, got %0d", want.ch, m_tuser[CH_W-1:0]);
					mismatch_count++;
				end
				if (m_tlast !== want.last) begin
					$error("frame_last: expected %b, got %b", want.last, m_tlast);
					mismatch_count++;
				end
				if (m_tuser[CH_W] !== want.err) begin
					$error("route_error: expected %b, got %b", want.err, m_tuser[CH_W]);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		stim_row_t   row;
		logic [31:0] smp;
		logic        blk;
		bit          frame_done;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_in = IN_CH_RST;
		cfg_out = OUT_CH_RST;
		cfg_pairs = PAIR_CNT_RST;
		cfg_src = ROUTE_RST;
		cfg_dst = ROUTE_RST;
		fill_pos = 3'd0;
		for (int i = 0; i < 8; i++)
			frame_copy[i] = 32'd0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[k]) begin
			row = directed_rows[k];
			if (row.kind == ROW_WRITE) begin
				settle(1'b1);
				cfg_write(row.idx, row.data);
			end else begin
				offer_sample(row.data, row.last, row.typed, row.err, row.out0, row.out1);
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			snd_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 70 : 0;
			rcv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 8 : 0;
			for (int set = 0; set < 2; set++) begin
				settle(1'b1);
				random_config(phase == 2 && set == 0);
				if (phase == 2 && set == 0)
					hold_asks++;
				for (int n = 0; n < ITEMS_PER_SET; n++) begin
					if (phase == 1 && set == 0 && n == ITEMS_PER_SET / 2)
						settle(1'b0);
					case ($urandom_range(0, 9))
						0: smp = 32'h00000000;
						1: smp = 32'hFFFFFFFF;
						2: smp = 32'h1 << $urandom_range(0, 31);
						default: smp = $urandom;
					endcase
					frame_done = ({1'b0, fill_pos} + 4'd1 >= eff_count(cfg_in));
					// mostly whole frames, with the odd buffer cut short
					blk = frame_done ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 24) == 0);
					offer_sample(smp, blk, 1'b0, 1'b0, 32'd0, 32'd0);
				end
			end
		end

		settle(1'b1);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

/* sim.f */
+incdir+rtl
rtl/acr_pkg.sv
rtl/acr_ram.sv
rtl/acr_cfg.sv
rtl/acr_drain.sv
rtl/audio_channel_router.sv
rtl/acr_checker.sv
test/audio_channel_router_tb.sv
